[hdl/sft_pkg.sv]
// ----------------------------------------------------------------------------
// sft_pkg
// shared types and codes of the sorted frequency table
// ----------------------------------------------------------------------------
`default_nettype none

package sft_pkg;

  localparam logic [2:0] OP_STORE  = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_UP     = 3'd2;
  localparam logic [2:0] OP_DOWN   = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;
  localparam logic [2:0] OP_SELECT = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [15:0] FREQ_RSV_LO = 16'h0000;
  localparam logic [15:0] FREQ_RSV_HI = 16'hFFFF;

  typedef enum logic [2:0] {
    K_NONE,
    K_STORE,
    K_REMOVE,
    K_UP,
    K_DOWN,
    K_FIND,
    K_SELECT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] freq;
    logic [5:0]  index;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] freq;
    logic [5:0]  index;
    logic [6:0]  count;
  } res_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } st_t;

endpackage

`default_nettype wire

[hdl/sft_front.sv]
// ----------------------------------------------------------------------------
// sft_front
// accepts request beats, classifies them and queues them for the table
// ----------------------------------------------------------------------------
`default_nettype none

module sft_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    op,
  input  wire logic [15:0]   freq,
  input  wire logic [5:0]    index,
  output sft_pkg::head_t     head,
  input  wire logic          pop
);

  sft_pkg::cmd_t q [2];
  logic          wp;
  logic          rp;
  logic [1:0]    qcnt;
  sft_pkg::cmd_t cmd_in;
  logic          push;

  always_comb begin
    cmd_in.freq  = freq;
    cmd_in.index = index;
    unique case (op)
      sft_pkg::OP_STORE: begin
        if (freq == sft_pkg::FREQ_RSV_LO || freq == sft_pkg::FREQ_RSV_HI) begin
          cmd_in.kind = sft_pkg::K_NONE;
        end else begin
          cmd_in.kind = sft_pkg::K_STORE;
        end
      end
      sft_pkg::OP_REMOVE: cmd_in.kind = sft_pkg::K_REMOVE;
      sft_pkg::OP_UP:     cmd_in.kind = sft_pkg::K_UP;
      sft_pkg::OP_DOWN:   cmd_in.kind = sft_pkg::K_DOWN;
      sft_pkg::OP_FIND:   cmd_in.kind = sft_pkg::K_FIND;
      sft_pkg::OP_SELECT: cmd_in.kind = sft_pkg::K_SELECT;
      default:            cmd_in.kind = sft_pkg::K_NONE;
    endcase
  end

  assign in_ready = (qcnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign head     = {(qcnt != 2'd0), q[rp]};

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      qcnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        qcnt <= qcnt + 2'd1;
      end else if (pop && !push) begin
        qcnt <= qcnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/sft_back.sv]
// ----------------------------------------------------------------------------
// sft_back
// cell chain of sorted entries: parallel compare, then shift and result
// ----------------------------------------------------------------------------
`default_nettype none

module sft_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  sft_pkg::head_t     head,
  output logic               pop,
  output sft_pkg::res_t      res,
  output logic               res_valid,
  input  wire logic          res_ready
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [TABLE_DEPTH-1:0][15:0] tbl;
  logic [TABLE_DEPTH-1:0][15:0] tbl_next;
  logic [TABLE_DEPTH-1:0][15:0] tbl_ins;
  logic [TABLE_DEPTH-1:0][15:0] tbl_rem;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                cnt_next;

  sft_pkg::st_t  state;
  sft_pkg::st_t  state_next;
  logic          go;
  sft_pkg::cmd_t cmd_q;

  logic [TABLE_DEPTH-1:0] vld;
  logic [TABLE_DEPTH-1:0] at_n;
  logic [TABLE_DEPTH-1:0] ge_c;
  logic [TABLE_DEPTH-1:0] gt_c;
  logic [TABLE_DEPTH-1:0] eq_c;
  logic [TABLE_DEPTH-1:0] ge_q;
  logic [TABLE_DEPTH-1:0] gt_q;
  logic [TABLE_DEPTH-1:0] eq_q;
  logic [TABLE_DEPTH-1:0] fge;
  logic [TABLE_DEPTH-1:0] fgt;
  logic [TABLE_DEPTH-1:0] p_oh;
  logic [TABLE_DEPTH-1:0] ins_rng;
  logic [TABLE_DEPTH-1:0] dn;
  logic [TABLE_DEPTH-1:0] sx;
  logic [TABLE_DEPTH-1:0] sel;

  logic          has_ge;
  logic          found;
  logic          full;
  logic          do_ins;
  logic          do_rem;
  logic [15:0]   pick_f;
  logic [IW-1:0] pick_i;
  logic [IW+5:0] ix_wide;
  logic [CW+6:0] cnt_wide;
  sft_pkg::res_t res_next;

  // per-cell status from the count
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      vld[i]  = (CW'(i) < cnt);
      at_n[i] = (CW'(i) == cnt);
    end
  end

  // parallel compare against the queue head
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ge_c[i] = vld[i] && (tbl[i] >= head.cmd.freq);
      gt_c[i] = vld[i] && (tbl[i] >  head.cmd.freq);
      eq_c[i] = vld[i] && (tbl[i] == head.cmd.freq);
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    go         = 1'b0;
    unique case (state)
      sft_pkg::S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = sft_pkg::S_EXEC;
        end
      end
      sft_pkg::S_EXEC: begin
        if (!res_valid || res_ready) begin
          go         = 1'b1;
          state_next = sft_pkg::S_IDLE;
        end
      end
      default: state_next = sft_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sft_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_q <= head.cmd;
      ge_q  <= ge_c;
      gt_q  <= gt_c;
      eq_q  <= eq_c;
    end
  end

  // first-hit one-hots and neighbor picks
  assign has_ge  = |ge_q;
  assign found   = |eq_q;
  assign full    = (cnt == CW'(TABLE_DEPTH));
  assign fge     = ge_q & ~{ge_q[TABLE_DEPTH-2:0], 1'b0};
  assign fgt     = gt_q & ~{gt_q[TABLE_DEPTH-2:0], 1'b0};
  assign p_oh    = has_ge ? fge : at_n;
  assign ins_rng = ge_q | at_n;
  assign dn      = vld & ~ge_q & (~{1'b0, vld[TABLE_DEPTH-1:1]} | {1'b1, ge_q[TABLE_DEPTH-1:1]});
  assign tbl_ins = {tbl[TABLE_DEPTH-2:0], 16'h0000};
  assign tbl_rem = {16'h0000, tbl[TABLE_DEPTH-1:1]};

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sx[i] = vld[i] && ({{IW{1'b0}}, cmd_q.index} == (IW + 6)'(i));
    end
  end

  always_comb begin
    case (cmd_q.kind)
      sft_pkg::K_UP:     sel = fgt;
      sft_pkg::K_DOWN:   sel = dn;
      sft_pkg::K_SELECT: sel = sx;
      default:           sel = p_oh;
    endcase
  end

  always_comb begin
    pick_f = 16'h0000;
    pick_i = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (sel[i]) begin
        pick_f = pick_f | tbl[i];
        pick_i = pick_i | IW'(i);
      end
    end
  end

  always_comb begin
    do_ins          = 1'b0;
    do_rem          = 1'b0;
    res_next.status = sft_pkg::ST_MISS;
    res_next.freq   = 16'h0000;
    ix_wide         = '0;
    case (cmd_q.kind)
      sft_pkg::K_STORE: begin
        if (found) begin
          res_next.status = sft_pkg::ST_OK;
          ix_wide         = {6'b000000, pick_i};
        end else if (full) begin
          res_next.status = sft_pkg::ST_FULL;
          if (has_ge) begin
            do_ins  = 1'b1;
            ix_wide = {6'b000000, pick_i};
          end
        end else begin
          do_ins          = 1'b1;
          res_next.status = sft_pkg::ST_OK;
          ix_wide         = {6'b000000, pick_i};
        end
      end
      sft_pkg::K_REMOVE: begin
        if (found) begin
          do_rem          = 1'b1;
          res_next.status = sft_pkg::ST_OK;
          ix_wide         = {6'b000000, pick_i};
        end
      end
      sft_pkg::K_FIND: begin
        if (found) begin
          res_next.status = sft_pkg::ST_OK;
          ix_wide         = {6'b000000, pick_i};
        end
      end
      sft_pkg::K_UP, sft_pkg::K_DOWN, sft_pkg::K_SELECT: begin
        if (|sel) begin
          res_next.status = sft_pkg::ST_OK;
          res_next.freq   = pick_f;
          ix_wide         = {6'b000000, pick_i};
        end
      end
      default: begin
      end
    endcase
    res_next.index = ix_wide[5:0];
    cnt_next = cnt;
    if (do_ins && !full) begin
      cnt_next = cnt + CW'(1);
    end else if (do_rem) begin
      cnt_next = cnt - CW'(1);
    end
    cnt_wide       = {7'b0000000, cnt_next};
    res_next.count = cnt_wide[6:0];
  end

  // cell update: insert shifts up from p, remove shifts down into p
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_next[i] = tbl[i];
      if (do_ins && ins_rng[i]) begin
        tbl_next[i] = p_oh[i] ? cmd_q.freq : tbl_ins[i];
      end else if (do_rem && ge_q[i]) begin
        tbl_next[i] = tbl_rem[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      tbl <= tbl_next;
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (go) begin
        cnt       <= cnt_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == sft_pkg::S_EXEC) |-> ($onehot0(fge) && $onehot0(fgt) && $onehot0(eq_q)))
    else $error("table lost ascending order");

  a_cnt_on_go: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (cnt != $past(cnt))) |-> $past(go))
    else $error("count moved without an executed request");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == sft_pkg::ST_FULL)) |-> full)
    else $error("full status with table not full");

endmodule

`default_nettype wire

[hdl/sorted_frequency_table.sv]
// ----------------------------------------------------------------------------
// sorted_frequency_table
// ascending duplicate-free preset frequency table with seek and lookup
// ----------------------------------------------------------------------------
// Each request beat yields exactly one result beat. In the table, the idle
// state compares the key against every cell of the chain in parallel and
// registers the flags; the execute state shifts the cells for store or remove
// and loads the output register once the result side is free; no new request
// is taken before the last is through. A two-deep request queue in front lets
// new beats arrive while a result waits to be taken. The table is empty right
// after reset, with no clearing pass; TABLE_DEPTH sets the number of cells.
`default_nettype none

module sorted_frequency_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // freq[15:0], index[21:16], zero pad
  input  wire logic [2:0]  s_tuser,   // op[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // result_freq[15:0], result_index[21:16],
                                      // fill_count[28:22], zero pad
  output logic [1:0]       m_tuser    // status[1:0]
);

  sft_pkg::head_t head;
  sft_pkg::res_t  res;
  logic           pop;

  sft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .op       (s_tuser),
    .freq     (s_tdata[15:0]),
    .index    (s_tdata[21:16]),
    .head     (head),
    .pop      (pop)
  );

  sft_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res       (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tdata = {3'b000, res.count, res.index, res.freq};
  assign m_tuser = res.status;

endmodule

`default_nettype wire
